FILE: src/foil_pkg.sv
// Shared constants, types and helpers for the fourth-order bidirectional IIR line.
// Used by foil_mac and fourth_order_bidirectional_iir_line; no dependencies.
package foil_pkg;

  localparam int MAX_LINE        = 256;
  localparam int ADDR_W          = $clog2(MAX_LINE);
  localparam int CNT_W           = ADDR_W + 1;
  localparam int COEFF_FRAC_BITS = 12;
  localparam int COEFF_W         = 16;
  localparam int SAMPLE_WIDTH    = 16;
  localparam int REC_WIDTH       = 40;
  localparam int OP_W            = REC_WIDTH + 1;
  localparam int PROD_W          = COEFF_W + OP_W;
  localparam int ACC_W           = 64;
  localparam int CFG_W           = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int MIN_LINE        = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAUSAL_FF     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANTI_FF       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAUSAL_BORDER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANTI_BORDER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 3'd5;

  localparam logic [COEFF_W-1:0] GAIN_RESET = COEFF_W'(1 << COEFF_FRAC_BITS);

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic en;
    logic first;
    logic sub;
  } mac_ctl_t;

  // Pick one packed coefficient out of a 64-bit register
  function automatic logic signed [COEFF_W-1:0] tap(input logic [CFG_W-1:0] word,
                                                    input logic [1:0] k);
    tap = word[COEFF_W*k +: COEFF_W];
  endfunction

endpackage

FILE: src/foil_mac.sv
// Shared signed multiply-accumulate unit: registered product, then accumulator.
// Depends on foil_pkg.
module foil_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  foil_pkg::mac_ctl_t                   ctl,
  input  logic signed [foil_pkg::COEFF_W-1:0]  coeff,
  input  logic signed [foil_pkg::OP_W-1:0]     operand,
  output logic signed [foil_pkg::ACC_W-1:0]    acc
);

  logic                                 prod_valid;
  logic                                 prod_first;
  logic                                 prod_sub;
  logic signed [foil_pkg::PROD_W-1:0]   prod;
  logic signed [foil_pkg::ACC_W-1:0]    base;
  logic signed [foil_pkg::ACC_W-1:0]    prod_ext;

  // Register the product and its control
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.en;
    end
    prod_first <= ctl.first;
    prod_sub   <= ctl.sub;
    prod       <= coeff * operand;
  end

  assign base     = prod_first ? '0 : acc;
  assign prod_ext = foil_pkg::ACC_W'(prod);

  // Add or subtract the product into the accumulator
  always_ff @(posedge clk) begin
    if (prod_valid) begin
      acc <= prod_sub ? (base - prod_ext) : (base + prod_ext);
    end
  end

endmodule

FILE: src/fourth_order_bidirectional_iir_line.sv
// Fourth-order bidirectional recursive line filter, top level.
// Load item: taken while idle. A closing load of n >= 4 samples starts filtering:
// a causal then an anticausal pass, each sample through fetch, MAC, drain, store
// and, when anticausal, gain states, all on one MAC; no item is taken meanwhile.
// Read item: S_PUT outputs the result (waiting while one is still held), then idle.
// Synchronous active-high reset clears control and configuration; the sample,
// recursion and result memories are not cleared. Depends on foil_pkg and foil_mac.
module fourth_order_bidirectional_iir_line (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     kind,
  input  logic signed [foil_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic                                     last_sample,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [foil_pkg::SAMPLE_WIDTH-1:0] filtered,
  output logic                                     last_of_line,
  output logic                                     short_line,
  input  logic                                     cfg_write,
  input  logic [foil_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [foil_pkg::CFG_W-1:0]               cfg_data
);

  localparam int AW  = foil_pkg::ADDR_W;
  localparam int CW  = foil_pkg::CNT_W;
  localparam int SW  = foil_pkg::SAMPLE_WIDTH;
  localparam int RW  = foil_pkg::REC_WIDTH;
  localparam int OW  = foil_pkg::OP_W;
  localparam int AC  = foil_pkg::ACC_W;
  localparam int FB  = foil_pkg::COEFF_FRAC_BITS;
  localparam logic [CW-1:0] LINE_MAX = CW'(foil_pkg::MAX_LINE);
  localparam logic [CW-1:0] LINE_MIN = CW'(foil_pkg::MIN_LINE);
  localparam logic signed [AC-1:0] REC_MAX = (AC'(1) <<< (RW - 1)) - AC'(1);
  localparam logic signed [AC-1:0] REC_MIN = -REC_MAX - AC'(1);
  localparam logic signed [AC-1:0] OUT_MAX = (AC'(1) <<< (SW - 1)) - AC'(1);
  localparam logic signed [AC-1:0] OUT_MIN = -OUT_MAX - AC'(1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_PUT    = 9'b000000010,
    S_FETCH  = 9'b000000100,
    S_MAC    = 9'b000001000,
    S_DRAIN  = 9'b000010000,
    S_STORE  = 9'b000100000,
    S_GAIN   = 9'b001000000,
    S_GDRAIN = 9'b010000000,
    S_GSTORE = 9'b100000000
  } state_t;

  state_t state;

  // Configuration registers
  logic [foil_pkg::CFG_W-1:0]   causal_ff;
  logic [foil_pkg::CFG_W-1:0]   feedback;
  logic [foil_pkg::CFG_W-1:0]   anti_ff;
  logic [foil_pkg::CFG_W-1:0]   causal_border;
  logic [foil_pkg::CFG_W-1:0]   anti_border;
  logic [foil_pkg::COEFF_W-1:0] gain;

  // Control
  logic [CW-1:0] load_count;
  logic [CW-1:0] read_index;
  logic [CW-1:0] line_length;
  logic [CW-1:0] t;
  logic [2:0]    step;
  logic          anti;
  logic          pend_last;
  logic          pend_short;

  // Memories
  logic signed [SW-1:0] line_store [foil_pkg::MAX_LINE];
  logic signed [RW-1:0] rec_store  [foil_pkg::MAX_LINE];
  logic signed [SW-1:0] res_store  [foil_pkg::MAX_LINE];
  logic signed [SW-1:0] line_rdata;
  logic signed [RW-1:0] rec_rdata;
  logic signed [SW-1:0] res_rdata;

  // Recursion window
  logic signed [SW-1:0] hx [4];
  logic signed [RW-1:0] hs [4];
  logic signed [SW-1:0] edge_reg;
  logic signed [RW-1:0] ra;

  // Datapath signals
  logic                          in_fire;
  logic                          load_fire;
  logic                          read_fire;
  logic                          read_ok;
  logic [CW-1:0]                 new_len;
  logic [CW-1:0]                 idx_full;
  logic [AW-1:0]                 idx;
  logic [1:0]                    kk;
  logic signed [SW-1:0]          edge_x;
  logic signed [SW-1:0]          x_op;
  logic signed [RW-1:0]          s_new;
  logic signed [SW-1:0]          y_new;
  foil_pkg::mac_ctl_t            mac_ctl;
  logic signed [foil_pkg::COEFF_W-1:0] mac_coeff;
  logic signed [OW-1:0]          mac_op;
  logic signed [AC-1:0]          acc;

  function automatic logic signed [RW-1:0] round_rec(input logic signed [AC-1:0] v);
    logic signed [AC-1:0] r;
    r = (v + (AC'(1) <<< (FB - 1))) >>> FB;
    if (r > REC_MAX) begin
      round_rec = REC_MAX[RW-1:0];
    end else if (r < REC_MIN) begin
      round_rec = REC_MIN[RW-1:0];
    end else begin
      round_rec = r[RW-1:0];
    end
  endfunction

  function automatic logic signed [SW-1:0] round_out(input logic signed [AC-1:0] v);
    logic signed [AC-1:0] r;
    r = (v + (AC'(1) <<< (2 * FB - 1))) >>> (2 * FB);
    if (r > OUT_MAX) begin
      round_out = OUT_MAX[SW-1:0];
    end else if (r < OUT_MIN) begin
      round_out = OUT_MIN[SW-1:0];
    end else begin
      round_out = r[SW-1:0];
    end
  endfunction

  function automatic logic signed [OW-1:0] scale_x(input logic signed [SW-1:0] x);
    scale_x = OW'(x) <<< FB;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign load_fire = in_fire && (kind == foil_pkg::KIND_LOAD);
  assign read_fire = in_fire && (kind == foil_pkg::KIND_READ);
  assign read_ok   = (read_index < line_length);
  assign new_len   = (load_count < LINE_MAX) ? load_count + CW'(1) : load_count;
  assign idx_full  = anti ? (line_length - CW'(1) - t) : t;
  assign idx       = idx_full[AW-1:0];
  assign kk        = step[1:0];
  assign edge_x    = (t == '0) ? line_rdata : edge_reg;
  assign s_new     = round_rec(acc);
  assign y_new     = round_out(acc);

  // Select the coefficient and operand for the current term
  always_comb begin
    mac_ctl   = '0;
    mac_coeff = '0;
    mac_op    = '0;
    x_op      = edge_x;
    if (state == S_MAC) begin
      mac_ctl.en    = 1'b1;
      mac_ctl.first = (step == 3'd0);
      if (!step[2]) begin
        if (anti) begin
          mac_coeff = foil_pkg::tap(anti_ff, kk);
          if (t > CW'(kk)) begin
            x_op = hx[kk];
          end
        end else begin
          mac_coeff = foil_pkg::tap(causal_ff, kk);
          if (kk == 2'd0) begin
            x_op = line_rdata;
          end else if (t >= CW'(kk)) begin
            x_op = hx[2'(kk - 2'd1)];
          end
        end
        mac_op = scale_x(x_op);
      end else begin
        mac_ctl.sub = 1'b1;
        if (t > CW'(kk)) begin
          mac_coeff = foil_pkg::tap(feedback, kk);
          mac_op    = OW'(hs[kk]);
        end else begin
          mac_coeff = foil_pkg::tap(anti ? anti_border : causal_border, kk);
          mac_op    = scale_x(edge_x);
        end
      end
    end else if (state == S_GAIN) begin
      mac_ctl.en    = 1'b1;
      mac_ctl.first = 1'b1;
      mac_coeff     = gain;
      mac_op        = OW'(rec_rdata) + OW'(ra);
    end
  end

  foil_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mac_ctl),
    .coeff   (mac_coeff),
    .operand (mac_op),
    .acc     (acc)
  );

  // Sequencer, counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      load_count    <= '0;
      read_index    <= '0;
      line_length   <= '0;
      t             <= '0;
      step          <= '0;
      anti          <= 1'b0;
      out_valid     <= 1'b0;
      causal_ff     <= '0;
      feedback      <= '0;
      anti_ff       <= '0;
      causal_border <= '0;
      anti_border   <= '0;
      gain          <= foil_pkg::GAIN_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          foil_pkg::CFG_CAUSAL_FF:     causal_ff     <= cfg_data;
          foil_pkg::CFG_FEEDBACK:      feedback      <= cfg_data;
          foil_pkg::CFG_ANTI_FF:       anti_ff       <= cfg_data;
          foil_pkg::CFG_CAUSAL_BORDER: causal_border <= cfg_data;
          foil_pkg::CFG_ANTI_BORDER:   anti_border   <= cfg_data;
          foil_pkg::CFG_GAIN:          gain          <= cfg_data[foil_pkg::COEFF_W-1:0];
          default: ;
        endcase
      end
      // Drop a taken item unless a new one replaces it this cycle
      if (out_valid && out_ready && state != S_PUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (load_fire) begin
            load_count <= new_len;
            if (last_sample) begin
              line_length <= new_len;
              load_count  <= '0;
              read_index  <= '0;
              t           <= '0;
              anti        <= 1'b0;
              if (new_len >= LINE_MIN) begin
                state <= S_FETCH;
              end
            end
          end else if (read_fire && read_ok) begin
            read_index <= read_index + CW'(1);
            state      <= S_PUT;
          end
        end
        S_PUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_FETCH: begin
          step  <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          step <= step + 3'd1;
          if (step == 3'd7) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_STORE;
        end
        S_STORE: begin
          if (anti) begin
            state <= S_GAIN;
          end else if (t == line_length - CW'(1)) begin
            anti  <= 1'b1;
            t     <= '0;
            state <= S_FETCH;
          end else begin
            t     <= t + CW'(1);
            state <= S_FETCH;
          end
        end
        S_GAIN: begin
          state <= S_GDRAIN;
        end
        S_GDRAIN: begin
          state <= S_GSTORE;
        end
        S_GSTORE: begin
          if (t == line_length - CW'(1)) begin
            state <= S_IDLE;
          end else begin
            t     <= t + CW'(1);
            state <= S_FETCH;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the recursion window and the output payload
  always_ff @(posedge clk) begin
    if (state == S_STORE) begin
      hx[0] <= line_rdata;
      hx[1] <= hx[0];
      hx[2] <= hx[1];
      hx[3] <= hx[2];
      hs[0] <= s_new;
      hs[1] <= hs[0];
      hs[2] <= hs[1];
      hs[3] <= hs[2];
      ra    <= s_new;
      if (t == '0) begin
        edge_reg <= line_rdata;
      end
    end
    if (state == S_IDLE && read_fire && read_ok) begin
      pend_last  <= (read_index == line_length - CW'(1));
      pend_short <= (line_length < LINE_MIN);
    end
    if (state == S_PUT && (!out_valid || out_ready)) begin
      filtered     <= pend_short ? '0 : res_rdata;
      last_of_line <= pend_last;
      short_line   <= pend_short;
    end
  end

  // Sample memory: write on load, read on fetch
  always_ff @(posedge clk) begin
    if (load_fire && load_count < LINE_MAX) begin
      line_store[load_count[AW-1:0]] <= sample;
    end
    if (state == S_FETCH) begin
      line_rdata <= line_store[idx];
    end
  end

  // Causal recursion memory
  always_ff @(posedge clk) begin
    if (state == S_STORE && !anti) begin
      rec_store[idx] <= s_new;
    end
    if (state == S_FETCH) begin
      rec_rdata <= rec_store[idx];
    end
  end

  // Result memory
  always_ff @(posedge clk) begin
    if (state == S_GSTORE) begin
      res_store[idx] <= y_new;
    end
    if (read_fire && read_ok) begin
      res_rdata <= res_store[read_index[AW-1:0]];
    end
  end

`ifndef SYNTH
  a_filter_long_line: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> (line_length >= LINE_MIN))
    else $error("filter pass started on a short line");
  a_index_in_line: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC) |-> (t < line_length))
    else $error("pass index beyond line length");
  a_drain_after_terms: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> ($past(state) == S_MAC && $past(step) == 3'd7))
    else $error("drain entered before all eight terms");
  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    read_index <= line_length)
    else $error("read index passed line length");
`endif

endmodule

FILE: dv/tb_fourth_order_bidirectional_iir_line.sv
// Self-checking testbench for the fourth-order bidirectional IIR line filter.
// Loads lines, reads them back and compares each pixel with a local fixed-point
// predictor; depends on foil_pkg and the fourth_order_bidirectional_iir_line RTL.
module tb_fourth_order_bidirectional_iir_line;

  typedef struct {
    logic                                     kind;
    logic signed [foil_pkg::SAMPLE_WIDTH-1:0] sample;
    logic                                     last;
  } line_item_t;

  typedef struct {
    logic signed [foil_pkg::SAMPLE_WIDTH-1:0] filtered;
    logic                                     line_end;
    logic                                     is_short;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = foil_pkg::KIND_LOAD;
  logic signed [foil_pkg::SAMPLE_WIDTH-1:0] sample = '0;
  logic last_sample = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [foil_pkg::SAMPLE_WIDTH-1:0] filtered;
  logic last_of_line;
  logic short_line;
  logic cfg_write = 1'b0;
  logic [foil_pkg::CFG_IDX_W-1:0] cfg_index = foil_pkg::CFG_CAUSAL_FF;
  logic [foil_pkg::CFG_W-1:0] cfg_data = '0;

  fourth_order_bidirectional_iir_line i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .sample(sample), .last_sample(last_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .filtered(filtered), .last_of_line(last_of_line), .short_line(short_line),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Stimulus and expectation stores
  line_item_t stim_items[$];
  pixel_t     pending_pixels[$];
  int         errors = 0;
  int         phase_items = 0;
  bit         quiet = 1'b0;
  bit         in_taken = 1'b0;
  int         in_gap = 0;
  int         out_gap = 0;
  int         stall_left = 0;
  int         hold_asked = 0;
  int         hold_served = 0;

  // Predictor state
  logic [foil_pkg::CFG_W-1:0]               coef[6];
  logic signed [foil_pkg::SAMPLE_WIDTH-1:0] line_mem[foil_pkg::MAX_LINE];
  longint                                   rec_mem[foil_pkg::MAX_LINE];
  logic signed [foil_pkg::SAMPLE_WIDTH-1:0] pix_mem[foil_pkg::MAX_LINE];
  int                                       loaded = 0;
  int                                       next_read = 0;
  int                                       line_len = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint coef_tap(int r, int k);
    logic [15:0] raw;
    raw = coef[r][16*k +: 16];
    return longint'($signed(raw));
  endfunction

  function automatic longint round_frac(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // Run both recursions over the closed line and fill the pixel store
  task automatic filter_line();
    int n;
    int j;
    longint one;
    longint acc;
    longint rc;
    longint ra;
    longint kg;
    n = line_len;
    one = 64'sd1 <<< foil_pkg::COEFF_FRAC_BITS;
    kg = coef_tap(5, 0);
    if (n < foil_pkg::MIN_LINE) begin
      for (int i = 0; i < n; i++) pix_mem[i] = '0;
      return;
    end
    for (int i = 0; i < n; i++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) begin
        j = (i >= k) ? i - k : 0;
        acc += coef_tap(0, k) * longint'(line_mem[j]) * one;
      end
      for (int k = 1; k <= 4; k++) begin
        if (i >= k) acc -= coef_tap(1, k - 1) * rec_mem[i - k];
        else acc -= coef_tap(3, k - 1) * longint'(line_mem[0]) * one;
      end
      rec_mem[i] = clamp(round_frac(acc, foil_pkg::COEFF_FRAC_BITS), foil_pkg::REC_WIDTH);
    end
    for (int p = n - 1; p >= 0; p--) begin
      acc = 0;
      for (int k = 0; k < 4; k++) begin
        j = p + 1 + k;
        if (j > n - 1) j = n - 1;
        acc += coef_tap(2, k) * longint'(line_mem[j]) * one;
      end
      for (int k = 1; k <= 4; k++) begin
        if (p + k <= n - 1) acc -= coef_tap(1, k - 1) * rec_mem[p + k];
        else acc -= coef_tap(4, k - 1) * longint'(line_mem[n - 1]) * one;
      end
      ra = clamp(round_frac(acc, foil_pkg::COEFF_FRAC_BITS), foil_pkg::REC_WIDTH);
      rc = rec_mem[p];
      rec_mem[p] = ra;
      pix_mem[p] = foil_pkg::SAMPLE_WIDTH'(clamp(round_frac(kg * rc + kg * ra,
                                                            2 * foil_pkg::COEFF_FRAC_BITS),
                                                 foil_pkg::SAMPLE_WIDTH));
    end
  endtask

  // Advance the predictor by one accepted item
  task automatic predict_item(logic k, logic signed [foil_pkg::SAMPLE_WIDTH-1:0] s, logic l);
    pixel_t px;
    if (k == foil_pkg::KIND_LOAD) begin
      if (loaded < foil_pkg::MAX_LINE) begin
        line_mem[loaded] = s;
        loaded++;
      end
      if (l) begin
        line_len = loaded;
        loaded = 0;
        next_read = 0;
        filter_line();
      end
    end else if (next_read < line_len) begin
      px.filtered = pix_mem[next_read];
      px.line_end = (next_read == line_len - 1);
      px.is_short = (line_len < foil_pkg::MIN_LINE);
      pending_pixels.push_back(px);
      next_read++;
    end
  endtask

  // Monitor: check results, then predict from accepted items
  always @(posedge clk) begin
    pixel_t px;
    in_taken = in_valid && in_ready && !rst;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t unexpected pixel: expected none, actual %0d", $time, filtered);
        errors++;
      end else begin
        px = pending_pixels.pop_front();
        if (filtered !== px.filtered) begin
          $display("%0t filtered: expected %0d actual %0d", $time, px.filtered, filtered);
          errors++;
        end
        if (last_of_line !== px.line_end) begin
          $display("%0t last_of_line: expected %0b actual %0b", $time, px.line_end,
                   last_of_line);
          errors++;
        end
        if (short_line !== px.is_short) begin
          $display("%0t short_line: expected %0b actual %0b", $time, px.is_short,
                   short_line);
          errors++;
        end
      end
    end
    if (in_taken) predict_item(kind, sample, last_sample);
  end

  // Driver: offer the next queued item, with random gaps
  always @(negedge clk) begin
    line_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (stim_items.size() > 0) begin
        it = stim_items.pop_front();
        in_valid <= 1'b1;
        kind <= it.kind;
        sample <= it.sample;
        last_sample <= it.last;
        if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold on request
  always @(negedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served++;
      stall_left = 3000;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 4) == 0) out_gap = $urandom_range(1, 7);
    end
  end

  task automatic push_item(logic k, logic [foil_pkg::SAMPLE_WIDTH-1:0] s, logic l);
    line_item_t it;
    it.kind = k;
    it.sample = s;
    it.last = l;
    stim_items.push_back(it);
    phase_items++;
  endtask

  function automatic logic [foil_pkg::SAMPLE_WIDTH-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'(($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // Load a full line of n samples, then issue the given number of reads
  task automatic push_line(int n, int reads);
    for (int i = 0; i < n; i++) push_item(foil_pkg::KIND_LOAD, rand_sample(), i == n - 1);
    for (int i = 0; i < reads; i++)
      push_item(foil_pkg::KIND_READ, 16'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // Hold until every item is in and every pixel is out, then let filtering settle
  task automatic wait_idle(int settle);
    @(posedge clk);
    while (stim_items.size() > 0 || in_valid || pending_pixels.size() > 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_regs(logic [foil_pkg::CFG_W-1:0] v[6]);
    for (int r = 0; r < 6; r++) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= foil_pkg::CFG_IDX_W'(r);
      cfg_data <= v[r];
      coef[r] = (r == foil_pkg::CFG_GAIN) ? (v[r] & 64'hffff) : v[r];
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [foil_pkg::CFG_W-1:0] mild_taps();
    logic [foil_pkg::CFG_W-1:0] w;
    for (int k = 0; k < 4; k++) w[16*k +: 16] = 16'($urandom_range(0, 2048) - 1024);
    return w;
  endfunction

  // Stimulus sequence
  initial begin
    logic [foil_pkg::CFG_W-1:0] v[6];
    int r;
    int n;
    for (int i = 0; i < 5; i++) coef[i] = '0;
    coef[foil_pkg::CFG_GAIN] = 64'(foil_pkg::GAIN_RESET);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset settings, then a pass-through causal filter
    @(posedge clk);
    push_item(foil_pkg::KIND_READ, 16'h7fff, 1'b1);
    push_line(4, 4);
    wait_idle(6500);
    v = '{64'h1000, 64'h0, 64'h0, 64'h0, 64'h0, 64'(foil_pkg::GAIN_RESET)};
    write_regs(v);
    @(posedge clk);
    push_item(foil_pkg::KIND_LOAD, 16'h7fff, 1'b0);
    push_item(foil_pkg::KIND_LOAD, 16'h8000, 1'b0);
    push_item(foil_pkg::KIND_LOAD, 16'h0000, 1'b0);
    push_item(foil_pkg::KIND_LOAD, 16'hffff, 1'b1);
    for (int i = 0; i < 5; i++) push_item(foil_pkg::KIND_READ, 16'hffff, 1'b1);
    push_line(1, 2);
    push_line(3, 3);
    push_line(5, 2);
    push_line(4, 4);

    // Random phases across coefficient settings, extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle(6500);
      case (ph % 3)
        0: v = '{mild_taps(), mild_taps(), mild_taps(), mild_taps(), mild_taps(),
                 64'($urandom_range(2048, 6144))};
        1: v = '{{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}};
        default: begin
          if (ph == 2) begin
            v = '{{64{1'b1}}, 64'h8000800080008000, {64{1'b1}}, 64'h7fff7fff7fff7fff,
                  64'h8000800080008000, 64'h7fff};
          end else begin
            v = '{64'h7fff7fff7fff7fff, {64{1'b1}}, 64'h7fff7fff7fff7fff,
                  64'h8000800080008000, {64{1'b1}}, 64'h8000};
          end
        end
      endcase
      write_regs(v);
      @(posedge clk);
      if (ph == 5) quiet = 1'b1;
      phase_items = 0;
      if (ph == 0) begin
        hold_asked++;
        push_line(40, 40);
      end
      while (phase_items < 300) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          case ($urandom_range(0, 39))
            0: n = foil_pkg::MAX_LINE;
            1: n = foil_pkg::MAX_LINE + $urandom_range(1, 4);
            2, 3, 4: n = $urandom_range(1, 3);
            default: n = $urandom_range(4, 16);
          endcase
          push_line(n, (n > foil_pkg::MAX_LINE ? foil_pkg::MAX_LINE : n)
                       + $urandom_range(0, 1));
        end else if (r < 82) begin
          n = $urandom_range(4, 12);
          push_line(n, $urandom_range(0, n - 1));
        end else if (r < 92) begin
          repeat ($urandom_range(1, 5))
            push_item(1'($urandom_range(0, 1)), 16'($urandom), 1'($urandom_range(0, 1)));
        end else begin
          push_item(foil_pkg::KIND_READ, 16'($urandom), 1'($urandom_range(0, 1)));
        end
      end
    end

    // Drain and report
    wait_idle(50);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
src/foil_pkg.sv
src/foil_mac.sv
src/fourth_order_bidirectional_iir_line.sv
dv/tb_fourth_order_bidirectional_iir_line.sv
